@@ rtl/button_debounce_click_hold_detector_core_macros.svh @@
// Assertion macros for the button debounce, click and hold detector.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BDCH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BDCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bdch_pkg.sv @@
// Shared types and constants for the button debounce, click and hold detector.
// No dependencies.
package bdch_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned TALLY_W = 4;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX  = 4'd15;
    localparam logic [TALLY_W-1:0] CLICK_MAX  = 4'd9;
    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [DELAY_W-1:0] FILTER_RESET   = 16'd20;

    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_FILTER    = 3'd1,
        REG_HOLD      = 3'd2,
        REG_MULTICLK  = 3'd3,
        REG_BISTABLE  = 3'd4,
        REG_ACTIVELOW = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] debounce_delay;
        logic [DELAY_W-1:0] noise_filter_delay;
        logic [DELAY_W-1:0] hold_time;
        logic [DELAY_W-1:0] multiclick_time;
        logic               bistable_mode;
        logic               active_low;
    } cfg_t;

    typedef struct packed {
        logic [TALLY_W-1:0] click_count;
        logic               hold_event;
        logic               change_event;
        logic               release_event;
        logic               press_event;
        logic               button_pressed;
    } result_t;

endpackage

@@ rtl/bdch_cfg.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on bdch_pkg.
module bdch_cfg
    import bdch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DEBOUNCE:  cfg_next.debounce_delay     = pwdata[DELAY_W-1:0];
                REG_FILTER:    cfg_next.noise_filter_delay = pwdata[DELAY_W-1:0];
                REG_HOLD:      cfg_next.hold_time = cfg_reg.bistable_mode ?
                                                    '0 : pwdata[DELAY_W-1:0];
                REG_MULTICLK:  cfg_next.multiclick_time    = pwdata[DELAY_W-1:0];
                REG_BISTABLE:
                begin
                    cfg_next.bistable_mode = pwdata[0];
                    if (pwdata[0])
                    begin
                        cfg_next.hold_time = '0;
                    end
                end
                REG_ACTIVELOW: cfg_next.active_low = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEBOUNCE:  prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_reg.debounce_delay};
            REG_FILTER:    prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_reg.noise_filter_delay};
            REG_HOLD:      prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_reg.hold_time};
            REG_MULTICLK:  prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_reg.multiclick_time};
            REG_BISTABLE:  prdata = {{(DATA_W-1){1'b0}}, cfg_reg.bistable_mode};
            REG_ACTIVELOW: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.active_low};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_delay     <= DEBOUNCE_RESET;
            cfg_reg.noise_filter_delay <= FILTER_RESET;
            cfg_reg.hold_time          <= '0;
            cfg_reg.multiclick_time    <= '0;
            cfg_reg.bistable_mode      <= 1'b0;
            cfg_reg.active_low         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/bdch_eval.sv @@
// Debounce, noise filter, hold and multiclick state with its per-poll update.
// Depends on bdch_pkg.
module bdch_eval
    import bdch_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               fire,
    input  logic               pin,
    input  logic [STAMP_W-1:0] now,
    output result_t            res
);

    logic               stable_reg,    stable_next;
    logic               cand_reg,      cand_next;
    logic [STAMP_W-1:0] lockout_reg,   lockout_next;
    logic [STAMP_W-1:0] filter_reg,    filter_next;
    logic [STAMP_W-1:0] last_chg_reg,  last_chg_next;
    logic               hold_rep_reg,  hold_rep_next;
    logic [TALLY_W-1:0] tally_reg,     tally_next;
    logic               primed_reg;

    logic               stable_cur;
    logic               cand_cur;
    logic               press_level;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] lock_age;
    logic [STAMP_W-1:0] filt_age;
    logic               lock_ok;
    logic               filt_ok;
    logic               changed;
    logic               pressed_ev;
    logic               hold_ev;
    logic [TALLY_W-1:0] clicks;

    assign stable_cur  = primed_reg ? stable_reg : pin;
    assign cand_cur    = primed_reg ? cand_reg : pin;
    assign press_level = !cfg.active_low;
    assign delta       = now - last_chg_reg;
    assign lock_age    = now - lockout_reg;
    assign filt_age    = now - filter_reg;
    assign lock_ok     = lock_age > {{(STAMP_W-DELAY_W){1'b0}}, cfg.debounce_delay};
    assign filt_ok     = filt_age > {{(STAMP_W-DELAY_W){1'b0}}, cfg.noise_filter_delay};

    always_comb
    begin
        stable_next   = stable_cur;
        cand_next     = cand_cur;
        lockout_next  = lockout_reg;
        filter_next   = filter_reg;
        last_chg_next = last_chg_reg;
        hold_rep_next = hold_rep_reg;
        tally_next    = tally_reg;
        changed       = 1'b0;
        pressed_ev    = 1'b0;
        hold_ev       = 1'b0;
        clicks        = '0;

        if (lock_ok)
        begin
            if (pin != stable_cur)
            begin
                if (pin != cand_cur)
                begin
                    cand_next   = pin;
                    filter_next = now;
                end
                else if (filt_ok)
                begin
                    lockout_next = now;
                    stable_next  = pin;
                    changed      = 1'b1;
                    pressed_ev   = (pin == press_level);
                end
            end
            else
            begin
                cand_next = stable_cur;
            end
        end

        if (!changed)
        begin
            if (!cfg.bistable_mode && (stable_cur == press_level))
            begin
                if ((tally_reg <= 4'd1) && (cfg.hold_time != '0) &&
                    (delta > {{(STAMP_W-DELAY_W){1'b0}}, cfg.hold_time}) && !hold_rep_reg)
                begin
                    hold_ev       = 1'b1;
                    hold_rep_next = 1'b1;
                end
            end
            else if ((cfg.multiclick_time != '0) &&
                     (delta > {{(STAMP_W-DELAY_W){1'b0}}, cfg.multiclick_time}))
            begin
                if (!hold_rep_reg && (tally_reg != '0) && (tally_reg <= CLICK_MAX))
                begin
                    clicks = tally_reg;
                end
                hold_rep_next = 1'b0;
                tally_next    = '0;
            end
        end
        else
        begin
            last_chg_next = now;
            if ((pressed_ev || cfg.bistable_mode) && (tally_reg < TALLY_MAX))
            begin
                tally_next = tally_reg + 4'd1;
            end
        end

        res.button_pressed = (stable_next == press_level);
        res.press_event    = changed && pressed_ev;
        res.release_event  = changed && !pressed_ev;
        res.change_event   = changed;
        res.hold_event     = hold_ev;
        res.click_count    = clicks;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= 1'b0;
            cand_reg     <= 1'b0;
            lockout_reg  <= '0;
            filter_reg   <= '0;
            last_chg_reg <= '0;
            hold_rep_reg <= 1'b0;
            tally_reg    <= '0;
            primed_reg   <= 1'b0;
        end
        else if (fire)
        begin
            stable_reg   <= stable_next;
            cand_reg     <= cand_next;
            lockout_reg  <= lockout_next;
            filter_reg   <= filter_next;
            last_chg_reg <= last_chg_next;
            hold_rep_reg <= hold_rep_next;
            tally_reg    <= tally_next;
            primed_reg   <= 1'b1;
        end
    end

endmodule

@@ rtl/button_debounce_click_hold_detector_core.sv @@
// Top level of the button debounce, click and hold detector.
// Depends on bdch_pkg, bdch_cfg, bdch_eval and the assertion macro header.
//
//   channel  | direction | transfer
//   s_axis   | in        | one poll: pin level and ms timestamp
//   m_axis   | out       | one result per poll: level, events, click count
//   apb      | in/out    | register write/read, six registers at 4*i
//
// A transferred poll is held in the input register and, when the result
// register is free, one update pass carries it into the result register on m_tdata.
// One poll per cycle is sustained while m_tready is high; the state update is a single pass.
// rst_n clears control state and the detector state asynchronously.
// A stalled m_tready holds the result; s_tready drops only when both
// registers are full.
`include "button_debounce_click_hold_detector_core_macros.svh"

module button_debounce_click_hold_detector_core
    import bdch_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] button_pressed, [1] press_event,
                                              // [2] release_event, [3] change_event,
                                              // [4] hold_event, [8:5] click_count
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t               cfg;
    result_t            res;
    logic               in_valid_reg,  in_valid_next;
    logic               in_pin_reg;
    logic [STAMP_W-1:0] in_now_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;
    logic               advance;
    logic               take;

    bdch_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdch_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .pin   (in_pin_reg),
        .now   (in_now_reg),
        .res   (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_res_reg};

    always_comb
    begin
        priority if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[STAMP_W:1];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    `BDCH_ASSERT_SAME(a_change_split, m_tvalid,
        (out_res_reg.change_event == (out_res_reg.press_event || out_res_reg.release_event))
        && !(out_res_reg.press_event && out_res_reg.release_event),
        "change_event does not match press/release")
    `BDCH_ASSERT_SAME(a_click_quiet, m_tvalid && (out_res_reg.click_count != '0),
        !out_res_reg.change_event && !out_res_reg.hold_event && !(out_res_reg.click_count > CLICK_MAX),
        "click report collides with another event or exceeds limit")
    `BDCH_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, s_tready,
        "input stalled with an empty result register")
    `BDCH_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg,
        "result register not filled after an update pass")

endmodule
